// File: hw/rtl/dac_pkg.sv
// Package for the three-layer directly addressable code store.
package dac_pkg;

  localparam int unsigned MaxElements = 4096;
  localparam int unsigned SlotDepth   = 2 * MaxElements;
  localparam int unsigned SlotW       = $clog2(SlotDepth);
  localparam int unsigned ElemW       = $clog2(MaxElements);
  localparam int unsigned FillW       = SlotW + 1;
  localparam int unsigned BlockOneW   = 7;
  localparam int unsigned BlockTwoW   = 15;
  localparam int unsigned RankOneD    = (SlotDepth + 127) / 128;
  localparam int unsigned RankOneW    = (RankOneD > 1) ? $clog2(RankOneD) : 1;
  localparam int unsigned RankTwoD    = (SlotDepth + 32767) / 32768;
  localparam int unsigned RankTwoW    = (RankTwoD > 1) ? $clog2(RankTwoD) : 1;

  localparam logic [1:0] CmdClear  = 2'd0;
  localparam logic [1:0] CmdAppend = 2'd1;
  localparam logic [1:0] CmdAccess = 2'd2;

  localparam logic [1:0] StOk    = 2'd0;
  localparam logic [1:0] StFull  = 2'd1;
  localparam logic [1:0] StRange = 2'd2;

endpackage

// File: hw/rtl/dac_ram.sv
// Generic single-port synchronous RAM with registered read.
module dac_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

// File: hw/rtl/dac_double_array_store.sv
// Top level: three-layer directly addressable code store for trie elements.
// From acceptance to result valid: clear loads the result register directly, append writes
// one slot per put state (PUT0, PUT1), then the result register, access reads each dependent layer.
// One transaction at a time: the next input is taken in the cycle after the result
// register loads; the result register does not load while an earlier result is stalled.
// Reset clears the fill counters, control and result; the memories are not cleared.
module dac_double_array_store (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  command_i,
  input  logic        is_fixed_i,
  input  logic        is_leaf_i,
  input  logic [31:0] base_or_link_i,
  input  logic [31:0] check_value_i,
  input  logic [12:0] position_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] slot_value_o,
  output logic        leaf_flag_o,
  output logic [1:0]  status_o,
  output logic [12:0] element_count_o,
  output logic [12:0] empty_count_o
);

  localparam int unsigned SW = dac_pkg::SlotW;
  localparam int unsigned FW = dac_pkg::FillW;
  localparam int unsigned EW = dac_pkg::ElemW;
  localparam int unsigned RankOneW_l = dac_pkg::RankOneW;

  typedef enum logic [2:0] {
    S_IDLE, S_PUT0, S_PUT1, S_RD1, S_RD2, S_RD3, S_DONE
  } state_e;

  state_e          state_q;
  logic [FW-1:0]   slot_fill_q, second_fill_q, third_fill_q;
  logic [EW:0]     empties_q;
  logic [31:0]     val_q;       // slot value being written, or result
  logic [31:0]     chk_q;
  logic            leaf_q, leafslot_q, flag_q;
  logic [SW-1:0]   pos_q;
  logic [1:0]      status_q;
  logic            out_valid_q;
  logic [FW-1:0]   rank1_cur_q;  // rank pointer of the block being appended to
  logic [FW-1:0]   rank2_q;      // single layer-two block

  // memory ports
  logic          we1, we2, we3, wem, rk_we;
  logic [SW-1:0] a1, a2, a3;
  logic [EW-1:0] am;
  logic [RankOneW_l-1:0] rk_a;
  logic [7:0]    wd1, rd1;
  logic [15:0]   wd2, rd2;
  logic [31:0]   wd3, rd3;
  logic          wdm, rdm;
  logic [FW-1:0] rk_rd;

  dac_ram #(.Width(8),  .Depth(dac_pkg::SlotDepth)) u_l1 (
    .clk_i, .we_i(we1), .addr_i(a1), .wdata_i(wd1), .rdata_o(rd1));
  dac_ram #(.Width(16), .Depth(dac_pkg::SlotDepth)) u_l2 (
    .clk_i, .we_i(we2), .addr_i(a2), .wdata_i(wd2), .rdata_o(rd2));
  dac_ram #(.Width(32), .Depth(dac_pkg::SlotDepth)) u_l3 (
    .clk_i, .we_i(we3), .addr_i(a3), .wdata_i(wd3), .rdata_o(rd3));
  dac_ram #(.Width(1),  .Depth(dac_pkg::MaxElements)) u_lm (
    .clk_i, .we_i(wem), .addr_i(am), .wdata_i(wdm), .rdata_o(rdm));
  dac_ram #(.Width(FW), .Depth(dac_pkg::RankOneD)) u_rk1 (
    .clk_i, .we_i(rk_we), .addr_i(rk_a), .wdata_i(second_fill_q), .rdata_o(rk_rd));

  // put-slot decode for the current value
  logic          is_put, full1, full2;
  logic          small1, small2, bnd1, bnd2;
  logic [FW-1:0] r1base, r2base, p2, p3;
  logic [FW-1:0] off1, off2;
  logic [RankOneW_l-1:0] rk1;

  assign is_put = (state_q == S_PUT0) || (state_q == S_PUT1);
  assign full1  = (slot_fill_q >= FW'(dac_pkg::SlotDepth));
  assign full2  = (second_fill_q >= FW'(dac_pkg::SlotDepth));
  assign small1 = (val_q < 32'd128);
  assign small2 = (val_q < 32'd32768);
  assign bnd1   = (slot_fill_q[dac_pkg::BlockOneW-1:0] == '0);
  assign bnd2   = (second_fill_q[dac_pkg::BlockTwoW-1:0] == '0);
  assign rk1    = RankOneW_l'(slot_fill_q >> dac_pkg::BlockOneW);
  // rank pointer is taken fresh at a block boundary
  assign r1base = bnd1 ? second_fill_q : rank1_cur_q;
  assign r2base = bnd2 ? third_fill_q : rank2_q;
  assign off1 = second_fill_q - r1base;
  assign off2 = third_fill_q - r2base;

  // access pointer arithmetic from registered reads
  assign p2 = rk_rd + FW'(rd1[7:1]);
  assign p3 = rank2_q + FW'(rd2[15:1]);

  always_comb begin
    we1 = 1'b0; we2 = 1'b0; we3 = 1'b0; wem = 1'b0; rk_we = 1'b0;
    a1  = slot_fill_q[SW-1:0];
    a2  = second_fill_q[SW-1:0];
    a3  = third_fill_q[SW-1:0];
    am  = EW'(slot_fill_q >> 1);
    rk_a = rk1;
    wd1 = '0; wd2 = '0; wd3 = val_q; wdm = leaf_q;
    if (state_q == S_IDLE) begin
      a1   = position_i[SW-1:0];
      am   = EW'(position_i >> 1);
      rk_a = RankOneW_l'(position_i >> dac_pkg::BlockOneW);
    end else if (state_q == S_RD1) begin
      a2 = p2[SW-1:0];
    end else if (state_q == S_RD2) begin
      a3 = p3[SW-1:0];
    end
    if (is_put && !full1) begin
      we1   = 1'b1;
      rk_we = bnd1;
      wem   = (state_q == S_PUT0);
      if (leafslot_q)  wd1 = val_q[7:0];
      else if (small1) wd1 = {val_q[6:0], 1'b0};
      else begin
        wd1 = {off1[6:0], 1'b1};
        if (!full2) begin
          we2 = 1'b1;
          if (small2) wd2 = {val_q[14:0], 1'b0};
          else begin
            wd2 = {off2[14:0], 1'b1};
            we3 = (third_fill_q < FW'(dac_pkg::SlotDepth));
          end
        end
      end
    end
  end

  logic [FW-1:0] elem_full;
  assign elem_full = FW'(2 * dac_pkg::MaxElements);

  // control, counters and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_IDLE;
      slot_fill_q     <= '0;
      second_fill_q   <= '0;
      third_fill_q    <= '0;
      empties_q       <= '0;
      out_valid_q     <= 1'b0;
      rank1_cur_q     <= '0;
      rank2_q         <= '0;
      slot_value_o    <= '0;
      leaf_flag_o     <= 1'b0;
      status_o        <= dac_pkg::StOk;
      element_count_o <= '0;
      empty_count_o   <= '0;
    end else begin
      if (state_q != S_DONE && out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: if (in_valid_i && in_ready_o) begin
          flag_q <= 1'b0;
          pos_q  <= position_i[SW-1:0];
          case (command_i)
            dac_pkg::CmdClear: begin
              slot_fill_q <= '0; second_fill_q <= '0;
              third_fill_q <= '0; empties_q <= '0;
              status_q <= dac_pkg::StOk;
              val_q    <= '0;
              state_q  <= S_DONE;
            end
            dac_pkg::CmdAppend: begin
              if (slot_fill_q >= elem_full) begin
                status_q <= dac_pkg::StFull;
                val_q    <= '0;
                state_q  <= S_DONE;
              end else begin
                status_q   <= dac_pkg::StOk;
                leaf_q     <= is_fixed_i & is_leaf_i;
                leafslot_q <= is_fixed_i & is_leaf_i;
                chk_q      <= is_fixed_i ? (check_value_i ^ 32'(slot_fill_q >> 1)) : '0;
                val_q      <= !is_fixed_i ? '0 : is_leaf_i ? base_or_link_i
                              : (base_or_link_i ^ 32'(slot_fill_q >> 1));
                if (!is_fixed_i) empties_q <= empties_q + 1'b1;
                state_q    <= S_PUT0;
              end
            end
            dac_pkg::CmdAccess: begin
              val_q <= '0;
              if (FW'(position_i) >= slot_fill_q) begin
                status_q <= dac_pkg::StRange;
                state_q  <= S_DONE;
              end else begin
                status_q <= dac_pkg::StOk;
                state_q  <= S_RD1;
              end
            end
            default: begin
              status_q <= dac_pkg::StOk;
              val_q    <= '0;
              state_q  <= S_DONE;
            end
          endcase
        end
        S_PUT0, S_PUT1: begin
          if (!full1) begin
            if (bnd1) rank1_cur_q <= second_fill_q;
            slot_fill_q <= slot_fill_q + 1'b1;
            if (!leafslot_q && !small1 && !full2) begin
              if (bnd2) rank2_q <= third_fill_q;
              second_fill_q <= second_fill_q + 1'b1;
              if (!small2 && third_fill_q < FW'(dac_pkg::SlotDepth))
                third_fill_q <= third_fill_q + 1'b1;
            end
          end
          leafslot_q <= 1'b0;
          if (state_q == S_PUT0) begin
            val_q   <= chk_q;
            state_q <= S_PUT1;
          end else begin
            val_q   <= '0;
            state_q <= S_DONE;
          end
        end
        S_RD1: begin
          flag_q <= rdm;
          if ((rdm && !pos_q[0]) || !rd1[0]) begin
            val_q   <= (rdm && !pos_q[0]) ? 32'(rd1) : 32'(rd1[7:1]);
            state_q <= S_DONE;
          end else if (p2 >= FW'(dac_pkg::SlotDepth)) begin
            val_q <= '0; state_q <= S_DONE;
          end else state_q <= S_RD2;
        end
        S_RD2: begin
          if (!rd2[0]) begin
            val_q <= 32'(rd2[15:1]); state_q <= S_DONE;
          end else if (p3 >= FW'(dac_pkg::SlotDepth)) begin
            val_q <= '0; state_q <= S_DONE;
          end else state_q <= S_RD3;
        end
        S_RD3: begin
          val_q   <= rd3;
          state_q <= S_DONE;
        end
        S_DONE: if (!out_valid_q || out_ready_i) begin
          out_valid_q     <= 1'b1;
          slot_value_o    <= val_q;
          leaf_flag_o     <= flag_q;
          status_o        <= status_q;
          element_count_o <= 13'(slot_fill_q >> 1);
          empty_count_o   <= 13'(empties_q);
          state_q         <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// File: hw/rtl/dac_checker.sv
// Port-level checker for the directly addressable code store.
module dac_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  status_o,
  input logic [12:0] element_count_o
);

  // result held while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o))
    else $error("result dropped under stall");

  // element count never exceeds the capacity
  a_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    element_count_o <= 13'(dac_pkg::MaxElements))
    else $error("element count over capacity");

  // status is a defined code
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o != 2'd3)
    else $error("undefined status");

  // an accepted transaction is not followed by another acceptance next cycle
  a_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("overlapping transactions");

endmodule

bind dac_double_array_store dac_checker u_dac_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
  .status_o, .element_count_o
);
